FILE: rtl/ewps_pkg.sv
// shared types and constants for the encoder period and speed block
package ewps_pkg;

    localparam int STAMP_BITS  = 24;
    localparam int PERIOD_BITS = STAMP_BITS + 1;
    localparam int POS_BITS    = 16;
    localparam int RES_BITS    = 17;
    localparam int WIN_BITS    = 4;
    localparam int TURN_BITS   = 16;
    localparam int WRAP_BITS   = 2;
    localparam int NUM_BITS    = 22;
    localparam int MAG_BITS    = 28;
    localparam int SPEED_BITS  = 29;
    localparam int CNT_BITS    = 5;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = RES_BITS;

    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_BITS = 2;
    localparam int Q_CNT_BITS = 3;

    localparam logic [PERIOD_BITS-1:0] STAMP_MAX = PERIOD_BITS'((64'd1 << STAMP_BITS) - 64'd1);
    localparam logic [NUM_BITS-1:0] SPEED_NUM = 22'd4000000;
    localparam int SPEED_MUL = 60;
    localparam logic [WRAP_BITS-1:0] STOP_WRAPS = 2'd2;

    localparam logic [RES_BITS-1:0] RES_RESET = 17'd4096;
    localparam logic [WIN_BITS-1:0] WIN_RESET = 4'd10;
    localparam logic [POS_BITS-1:0] FWD_MARK_RESET = 16'd10;
    localparam logic [POS_BITS-1:0] BWD_MARK_RESET = 16'd4086;

    localparam logic [CFG_IDX_BITS-1:0] REG_RESOLUTION = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW     = 1'b1;

    typedef enum logic [1:0] {
        FUNC_SAMPLE = 2'd0,
        FUNC_WRAP   = 2'd1,
        FUNC_REARM  = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        CROSS_NONE = 2'd0,
        CROSS_FWD  = 2'd1,
        CROSS_BACK = 2'd2
    } cross_t;

    typedef struct packed {
        logic [TURN_BITS-1:0]   turns;
        logic [PERIOD_BITS-1:0] period;
        logic                   back;
        logic                   valid;
        cross_t                 crossed;
        logic                   div_req;
    } entry_t;

endpackage

FILE: rtl/ewps_front.sv
// front end: accepts items, tracks marks and crossing state, pushes results to the queue
module ewps_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [ewps_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [ewps_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                 in_valid,
    input  logic [1:0]                           func,
    input  logic [ewps_pkg::POS_BITS-1:0]        encoder_count,
    input  logic [ewps_pkg::STAMP_BITS-1:0]      timestamp,
    input  logic                                 q_full,
    output logic                                 push,
    output ewps_pkg::entry_t                     push_entry
);

    logic [ewps_pkg::RES_BITS-1:0]    res_reg, res_next;
    logic [ewps_pkg::WIN_BITS-1:0]    wh_reg, wh_next;
    logic [ewps_pkg::POS_BITS-1:0]    fwd_reg, fwd_next;
    logic [ewps_pkg::POS_BITS-1:0]    bwd_reg, bwd_next;
    logic [ewps_pkg::TURN_BITS-1:0]   turns_reg, turns_next;
    logic [ewps_pkg::STAMP_BITS-1:0]  last_reg, last_next;
    logic [ewps_pkg::PERIOD_BITS-1:0] period_reg, period_next;
    logic                             back_reg, back_next;
    logic                             valid_reg, valid_next;
    logic [ewps_pkg::WRAP_BITS-1:0]   wrap_reg, wrap_next;

    logic [ewps_pkg::RES_BITS-1:0]    fwd_sum;
    logic [ewps_pkg::RES_BITS-1:0]    bwd_sum;
    logic [ewps_pkg::POS_BITS-1:0]    arm_fwd;
    logic [ewps_pkg::POS_BITS-1:0]    arm_bwd;
    logic [ewps_pkg::PERIOD_BITS-1:0] diff;
    logic [ewps_pkg::PERIOD_BITS-1:0] period_new;
    logic [ewps_pkg::WRAP_BITS-1:0]   wrap_inc;
    ewps_pkg::cross_t                 crossed;

    // marks around the sample position, modulo resolution
    always_comb
    begin
        fwd_sum = {1'b0, encoder_count} + ewps_pkg::RES_BITS'(wh_reg);
        if (fwd_sum >= res_reg)
        begin
            fwd_sum = fwd_sum - res_reg;
        end
        bwd_sum = {1'b0, encoder_count} - ewps_pkg::RES_BITS'(wh_reg);
        if (encoder_count < ewps_pkg::POS_BITS'(wh_reg))
        begin
            bwd_sum = bwd_sum + res_reg;
        end
        arm_fwd = fwd_sum[ewps_pkg::POS_BITS-1:0];
        arm_bwd = bwd_sum[ewps_pkg::POS_BITS-1:0];
    end

    // elapsed time on the down counter, with wrap
    always_comb
    begin
        diff = {1'b0, last_reg} - {1'b0, timestamp};
        if (last_reg <= timestamp)
        begin
            period_new = diff + ewps_pkg::STAMP_MAX;
        end
        else
        begin
            period_new = diff;
        end
    end

    always_comb
    begin
        res_next    = res_reg;
        wh_next     = wh_reg;
        fwd_next    = fwd_reg;
        bwd_next    = bwd_reg;
        turns_next  = turns_reg;
        last_next   = last_reg;
        period_next = period_reg;
        back_next   = back_reg;
        valid_next  = valid_reg;
        wrap_next   = wrap_reg;
        crossed     = ewps_pkg::CROSS_NONE;
        push        = in_valid && !q_full;
        wrap_inc    = (wrap_reg < ewps_pkg::STOP_WRAPS) ? wrap_reg + 1'b1 : wrap_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                ewps_pkg::REG_RESOLUTION: res_next = cfg_data[ewps_pkg::RES_BITS-1:0];
                ewps_pkg::REG_WINDOW:     wh_next  = cfg_data[ewps_pkg::WIN_BITS-1:0];
                default:                  res_next = res_reg;
            endcase
        end

        if (push)
        begin
            case (func)
                ewps_pkg::FUNC_SAMPLE:
                begin
                    if (encoder_count == fwd_reg)
                    begin
                        crossed = ewps_pkg::CROSS_FWD;
                    end
                    else if (encoder_count == bwd_reg)
                    begin
                        crossed = ewps_pkg::CROSS_BACK;
                    end
                    if (crossed != ewps_pkg::CROSS_NONE)
                    begin
                        fwd_next    = arm_fwd;
                        bwd_next    = arm_bwd;
                        turns_next  = (crossed == ewps_pkg::CROSS_FWD) ?
                                      turns_reg + 1'b1 : turns_reg - 1'b1;
                        period_next = period_new;
                        back_next   = (crossed == ewps_pkg::CROSS_BACK);
                        valid_next  = 1'b1;
                        wrap_next   = '0;
                        last_next   = timestamp;
                    end
                end
                ewps_pkg::FUNC_WRAP:
                begin
                    wrap_next = wrap_inc;
                    if (wrap_inc >= ewps_pkg::STOP_WRAPS)
                    begin
                        wrap_next  = ewps_pkg::STOP_WRAPS;
                        valid_next = 1'b0;
                    end
                end
                ewps_pkg::FUNC_REARM:
                begin
                    fwd_next = arm_fwd;
                    bwd_next = arm_bwd;
                end
                default:
                begin
                    crossed = ewps_pkg::CROSS_NONE;
                end
            endcase
        end

        push_entry.turns   = turns_next;
        push_entry.period  = period_next;
        push_entry.back    = back_next;
        push_entry.valid   = valid_next;
        push_entry.crossed = crossed;
        push_entry.div_req = (crossed != ewps_pkg::CROSS_NONE) && (period_new != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg    <= ewps_pkg::RES_RESET;
            wh_reg     <= ewps_pkg::WIN_RESET;
            fwd_reg    <= ewps_pkg::FWD_MARK_RESET;
            bwd_reg    <= ewps_pkg::BWD_MARK_RESET;
            turns_reg  <= '0;
            last_reg   <= '0;
            period_reg <= '0;
            back_reg   <= 1'b0;
            valid_reg  <= 1'b0;
            wrap_reg   <= '0;
        end
        else
        begin
            res_reg    <= res_next;
            wh_reg     <= wh_next;
            fwd_reg    <= fwd_next;
            bwd_reg    <= bwd_next;
            turns_reg  <= turns_next;
            last_reg   <= last_next;
            period_reg <= period_next;
            back_reg   <= back_next;
            valid_reg  <= valid_next;
            wrap_reg   <= wrap_next;
        end
    end

    a_wrap_bound: assert property (@(posedge clk) disable iff (!rst_n)
        wrap_reg <= ewps_pkg::STOP_WRAPS)
        else $error("wrap tick count above stop limit");

endmodule

FILE: rtl/ewps_queue.sv
// short result queue between front and back
module ewps_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  ewps_pkg::entry_t push_entry,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output ewps_pkg::entry_t head
);

    ewps_pkg::entry_t                 mem_reg [ewps_pkg::Q_DEPTH];
    logic [ewps_pkg::Q_PTR_BITS-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [ewps_pkg::Q_PTR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [ewps_pkg::Q_CNT_BITS-1:0]  count_reg, count_next;

    assign full       = (count_reg == ewps_pkg::Q_CNT_BITS'(ewps_pkg::Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= ewps_pkg::Q_CNT_BITS'(ewps_pkg::Q_DEPTH))
        else $error("queue count above depth");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("queue popped while empty");

endmodule

FILE: rtl/ewps_back.sv
// back end: speed divider, scaling and output register
module ewps_back (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  head_valid,
    input  ewps_pkg::entry_t                      head,
    output logic                                  pop,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [ewps_pkg::TURN_BITS-1:0]        out_turns,
    output logic [ewps_pkg::STAMP_BITS-1:0]       out_period,
    output logic                                  out_back,
    output logic                                  out_pvalid,
    output logic [ewps_pkg::SPEED_BITS-1:0]       out_speed,
    output logic [1:0]                            out_crossed
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_DIV   = 4'b0010,
        ST_SCALE = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    state_t                               state_reg, state_next;
    ewps_pkg::entry_t                     work_reg, work_next;
    logic [ewps_pkg::PERIOD_BITS-1:0]     rem_reg, rem_next;
    logic [ewps_pkg::NUM_BITS-1:0]        quo_reg, quo_next;
    logic [ewps_pkg::CNT_BITS-1:0]        cnt_reg, cnt_next;
    logic [ewps_pkg::MAG_BITS-1:0]        mag_reg, mag_next;

    logic                                 out_valid_reg, out_valid_next;
    logic [ewps_pkg::TURN_BITS-1:0]       turns_reg, turns_next;
    logic [ewps_pkg::STAMP_BITS-1:0]      period_reg, period_next;
    logic                                 back_reg, back_next;
    logic                                 pvalid_reg, pvalid_next;
    logic [ewps_pkg::SPEED_BITS-1:0]      speed_reg, speed_next;
    logic [1:0]                           crossed_reg, crossed_next;

    logic                                 slot_free;
    logic [ewps_pkg::PERIOD_BITS:0]       rem_shift;
    logic [ewps_pkg::PERIOD_BITS:0]       rem_diff;
    ewps_pkg::entry_t                     load_entry;
    logic                                 load;

    function automatic logic [ewps_pkg::SPEED_BITS-1:0] signed_speed(
        input ewps_pkg::entry_t             e,
        input logic [ewps_pkg::MAG_BITS-1:0] mag
    );
        logic [ewps_pkg::SPEED_BITS-1:0] m;
        m = {1'b0, mag};
        if (e.valid && (e.period != '0))
        begin
            return e.back ? m : ('0 - m);
        end
        return '0;
    endfunction

    assign slot_free = !out_valid_reg || !out_stall;
    assign rem_shift = {rem_reg, ewps_pkg::SPEED_NUM[cnt_reg]};
    assign rem_diff  = rem_shift - {1'b0, work_reg.period};

    always_comb
    begin
        state_next     = state_reg;
        work_next      = work_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        mag_next       = mag_reg;
        pop            = 1'b0;
        load           = 1'b0;
        load_entry     = head;

        case (state_reg)
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    if (head.div_req)
                    begin
                        pop        = 1'b1;
                        work_next  = head;
                        rem_next   = '0;
                        quo_next   = '0;
                        cnt_next   = ewps_pkg::CNT_BITS'(ewps_pkg::NUM_BITS - 1);
                        state_next = ST_DIV;
                    end
                    else if (slot_free)
                    begin
                        pop  = 1'b1;
                        load = 1'b1;
                    end
                end
            end
            ST_DIV:
            begin
                // one quotient bit per cycle
                if (!rem_diff[ewps_pkg::PERIOD_BITS])
                begin
                    rem_next = rem_diff[ewps_pkg::PERIOD_BITS-1:0];
                    quo_next = {quo_reg[ewps_pkg::NUM_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_shift[ewps_pkg::PERIOD_BITS-1:0];
                    quo_next = {quo_reg[ewps_pkg::NUM_BITS-2:0], 1'b0};
                end
                if (cnt_reg == '0)
                begin
                    state_next = ST_SCALE;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_SCALE:
            begin
                mag_next   = {{(ewps_pkg::MAG_BITS - ewps_pkg::NUM_BITS){1'b0}}, quo_reg}
                             * ewps_pkg::MAG_BITS'(ewps_pkg::SPEED_MUL);
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                load_entry = work_reg;
                if (slot_free)
                begin
                    load       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        turns_next     = turns_reg;
        period_next    = period_reg;
        back_next      = back_reg;
        pvalid_next    = pvalid_reg;
        speed_next     = speed_reg;
        crossed_next   = crossed_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            turns_next     = load_entry.turns;
            period_next    = load_entry.period[ewps_pkg::STAMP_BITS-1:0];
            back_next      = load_entry.back;
            pvalid_next    = load_entry.valid;
            speed_next     = signed_speed(load_entry, mag_reg);
            crossed_next   = load_entry.crossed;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg    <= work_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        cnt_reg     <= cnt_next;
        mag_reg     <= mag_next;
        turns_reg   <= turns_next;
        period_reg  <= period_next;
        back_reg    <= back_next;
        pvalid_reg  <= pvalid_next;
        speed_reg   <= speed_next;
        crossed_reg <= crossed_next;
    end

    assign out_valid   = out_valid_reg;
    assign out_turns   = turns_reg;
    assign out_period  = period_reg;
    assign out_back    = back_reg;
    assign out_pvalid  = pvalid_reg;
    assign out_speed   = speed_reg;
    assign out_crossed = crossed_reg;

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (work_reg.period != '0))
        else $error("divide started on zero period");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && cnt_reg == '0) |=> (state_reg == ST_SCALE))
        else $error("divider did not finish into scaling");

endmodule

FILE: rtl/encoder_window_period_speed.sv
// top level of the encoder window period and speed block
//
// input channel: in_valid / in_stall with func, encoder_count and timestamp;
// func selects a position sample, a timestamp wrap tick or a re-arm of the marks.
// output channel: out_valid / out_stall, one result item per input item, in order,
// carrying turn count, period, direction, period valid flag, speed and crossing code.
// configuration: cfg_we writes cfg_data into register cfg_index
// (0 encoder resolution, 1 window half width); marks take new values when next placed.
// the front end updates all position state in the cycle an item is accepted
// and places the result in a four-entry queue; in_stall is high while it is full.
// items that need no new speed pass from the queue straight to the output register.
// a mark crossing with a nonzero period runs a radix-2 divider for 22 quotient bits
// and a scaling step before delivery; the back end takes no new item meanwhile.
// sustained rate is one item per cycle without crossings while out_stall is low.
// when out_stall is high the result register holds and the queue fills behind it.
// reset sets marks at 10 and 4086, resolution 4096, stopped, no turns, nothing queued.
module encoder_window_period_speed (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       cfg_we,
    input  logic [ewps_pkg::CFG_IDX_BITS-1:0]          cfg_index,
    input  logic [ewps_pkg::CFG_DATA_BITS-1:0]         cfg_data,
    input  logic                                       in_valid,
    output logic                                       in_stall,
    input  logic [1:0]                                 func,
    input  logic [ewps_pkg::POS_BITS-1:0]              encoder_count,
    input  logic [ewps_pkg::STAMP_BITS-1:0]            timestamp,
    output logic                                       out_valid,
    input  logic                                       out_stall,
    output logic signed [ewps_pkg::TURN_BITS-1:0]      turn_count,
    output logic [ewps_pkg::STAMP_BITS-1:0]            period_ticks,
    output logic                                       direction_back,
    output logic                                       period_valid,
    output logic signed [ewps_pkg::SPEED_BITS-1:0]     speed_rpm,
    output logic [1:0]                                 crossed
);

    logic                                   push;
    ewps_pkg::entry_t                       push_entry;
    logic                                   q_full;
    logic                                   pop;
    logic                                   head_valid;
    ewps_pkg::entry_t                       head;
    logic [ewps_pkg::TURN_BITS-1:0]         turns_u;
    logic [ewps_pkg::SPEED_BITS-1:0]        speed_u;

    assign in_stall = q_full;

    ewps_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .func          (func),
        .encoder_count (encoder_count),
        .timestamp     (timestamp),
        .q_full        (q_full),
        .push          (push),
        .push_entry    (push_entry)
    );

    ewps_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    ewps_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head        (head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_turns   (turns_u),
        .out_period  (period_ticks),
        .out_back    (direction_back),
        .out_pvalid  (period_valid),
        .out_speed   (speed_u),
        .out_crossed (crossed)
    );

    assign turn_count = $signed(turns_u);
    assign speed_rpm  = $signed(speed_u);

endmodule

FILE: sim/ewps_checker.sv
`timescale 1ns / 1ps
// checker for the encoder period and speed block: predicts each result item and compares it
module ewps_checker
    import ewps_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [CFG_IDX_BITS-1:0]        cfg_index,
    input  logic [CFG_DATA_BITS-1:0]       cfg_data,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic [1:0]                     func,
    input  logic [POS_BITS-1:0]            encoder_count,
    input  logic [STAMP_BITS-1:0]          timestamp,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic signed [TURN_BITS-1:0]    turn_count,
    input  logic [STAMP_BITS-1:0]          period_ticks,
    input  logic                           direction_back,
    input  logic                           period_valid,
    input  logic signed [SPEED_BITS-1:0]   speed_rpm,
    input  logic [1:0]                     crossed,
    output int                             errors,
    output int                             outstanding,
    output int                             crossings,
    output int                             stops
);

    typedef struct packed {
        logic [TURN_BITS-1:0]   turns;
        logic [STAMP_BITS-1:0]  period;
        logic                   back;
        logic                   valid;
        logic [SPEED_BITS-1:0]  speed;
        cross_t                 hit;
    } reading_t;

    reading_t                pending_readings[$];

    logic [RES_BITS-1:0]     res_cfg;
    logic [WIN_BITS-1:0]     win_cfg;
    logic [POS_BITS-1:0]     fwd_mark;
    logic [POS_BITS-1:0]     bwd_mark;
    logic [TURN_BITS-1:0]    turn_total;
    logic [STAMP_BITS-1:0]   last_stamp;
    logic [STAMP_BITS-1:0]   held_period;
    logic                    back_dir;
    logic                    measured;
    logic [WRAP_BITS-1:0]    wrap_seen;

    task automatic place_marks(input logic [POS_BITS-1:0] pos);
        int fwd;
        int bwd;
        fwd = int'(pos) + int'(win_cfg);
        bwd = int'(pos) - int'(win_cfg);
        if (fwd >= int'(res_cfg))
            fwd -= int'(res_cfg);
        if (bwd < 0)
            bwd += int'(res_cfg);
        fwd_mark = fwd[POS_BITS-1:0];
        bwd_mark = bwd[POS_BITS-1:0];
    endtask

    task automatic follow_encoder(input logic [1:0] f, input logic [POS_BITS-1:0] cnt,
                                  input logic [STAMP_BITS-1:0] now, output reading_t r);
        cross_t                  hit;
        logic [PERIOD_BITS-1:0]  span;
        int unsigned             mag;
        logic [SPEED_BITS-1:0]   spd;
        hit = CROSS_NONE;
        spd = '0;
        case (f)
            FUNC_SAMPLE: begin
                if (cnt == fwd_mark)
                    hit = CROSS_FWD;
                else if (cnt == bwd_mark)
                    hit = CROSS_BACK;
                if (hit != CROSS_NONE) begin
                    place_marks(cnt);
                    if (hit == CROSS_FWD)
                        turn_total = turn_total + 1'b1;
                    else
                        turn_total = turn_total - 1'b1;
                    if (last_stamp <= now)
                        span = STAMP_MAX + last_stamp - now;
                    else
                        span = last_stamp - now;
                    held_period = span[STAMP_BITS-1:0];
                    back_dir = (hit == CROSS_BACK);
                    measured = 1'b1;
                    wrap_seen = '0;
                    last_stamp = now;
                    crossings++;
                end
            end
            FUNC_WRAP: begin
                if (wrap_seen < STOP_WRAPS)
                    wrap_seen = wrap_seen + 1'b1;
                if (wrap_seen >= STOP_WRAPS) begin
                    wrap_seen = STOP_WRAPS;
                    if (measured)
                        stops++;
                    measured = 1'b0;
                end
            end
            FUNC_REARM: place_marks(cnt);
            default: ;
        endcase
        if (measured && held_period != '0) begin
            mag = SPEED_MUL * (32'(SPEED_NUM) / 32'(held_period));
            spd = mag[SPEED_BITS-1:0];
            if (!back_dir)
                spd = -spd;
        end
        r.turns = turn_total;
        r.period = held_period;
        r.back = back_dir;
        r.valid = measured;
        r.speed = spd;
        r.hit = hit;
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        reading_t want;
        reading_t got;
        if (!rst_n) begin
            res_cfg = RES_RESET;
            win_cfg = WIN_RESET;
            place_marks('0);
            turn_total = '0;
            last_stamp = '0;
            held_period = '0;
            back_dir = 1'b0;
            measured = 1'b0;
            wrap_seen = '0;
            pending_readings.delete();
            errors = 0;
            crossings = 0;
            stops = 0;
            outstanding <= 0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_RESOLUTION)
                    res_cfg = cfg_data[RES_BITS-1:0];
                else if (cfg_index == REG_WINDOW)
                    win_cfg = cfg_data[WIN_BITS-1:0];
            end
            if (out_valid && !out_stall) begin
                got.turns = turn_count;
                got.period = period_ticks;
                got.back = direction_back;
                got.valid = period_valid;
                got.speed = speed_rpm;
                got.hit = cross_t'(crossed);
                if (pending_readings.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: result item with none expected: turns=%h period=%h",
                                 $realtime, got.turns, got.period);
                end else begin
                    want = pending_readings.pop_front();
                    if (got.turns !== want.turns || got.period !== want.period ||
                        got.back !== want.back || got.valid !== want.valid ||
                        got.speed !== want.speed || got.hit !== want.hit) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("%0t: mismatch, expected turns=%h period=%h back=%b valid=%b speed=%h crossed=%0d",
                                     $realtime, want.turns, want.period, want.back,
                                     want.valid, want.speed, want.hit);
                            $display("%0t:           actual turns=%h period=%h back=%b valid=%b speed=%h crossed=%0d",
                                     $realtime, got.turns, got.period, got.back,
                                     got.valid, got.speed, got.hit);
                        end
                    end
                end
            end
            if (in_valid && !in_stall) begin
                follow_encoder(func, encoder_count, timestamp, want);
                pending_readings.push_back(want);
            end
            outstanding <= pending_readings.size();
        end
    end

endmodule

FILE: sim/tb_encoder_window_period_speed.sv
`timescale 1ns / 1ps
// testbench top for the encoder period and speed block: stimulus, stalls and verdict
module tb_encoder_window_period_speed;
    import ewps_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int         STAMP_SPAN  = 1 << STAMP_BITS;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]       cfg_index = REG_RESOLUTION;
    logic [CFG_DATA_BITS-1:0]      cfg_data = '0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic [1:0]                    func = FUNC_SAMPLE;
    logic [POS_BITS-1:0]           encoder_count = '0;
    logic [STAMP_BITS-1:0]         timestamp = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic signed [TURN_BITS-1:0]   turn_count;
    logic [STAMP_BITS-1:0]         period_ticks;
    logic                          direction_back;
    logic                          period_valid;
    logic signed [SPEED_BITS-1:0]  speed_rpm;
    logic [1:0]                    crossed;

    int checker_errors;
    int outstanding;
    int crossings;
    int stops;
    int items_sent = 0;
    int settings_run = 1;
    int burst_left = 0;
    int stamp = 24'h600000;

    always #5 clk = ~clk;

    encoder_window_period_speed DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .func           (func),
        .encoder_count  (encoder_count),
        .timestamp      (timestamp),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .turn_count     (turn_count),
        .period_ticks   (period_ticks),
        .direction_back (direction_back),
        .period_valid   (period_valid),
        .speed_rpm      (speed_rpm),
        .crossed        (crossed)
    );

    ewps_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .func           (func),
        .encoder_count  (encoder_count),
        .timestamp      (timestamp),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .turn_count     (turn_count),
        .period_ticks   (period_ticks),
        .direction_back (direction_back),
        .period_valid   (period_valid),
        .speed_rpm      (speed_rpm),
        .crossed        (crossed),
        .errors         (checker_errors),
        .outstanding    (outstanding),
        .crossings      (crossings),
        .stops          (stops)
    );

    task automatic send_item(input logic [1:0] f, input logic [POS_BITS-1:0] cnt,
                             input logic [STAMP_BITS-1:0] ts);
        in_valid <= 1'b1;
        func <= f;
        encoder_count <= cnt;
        timestamp <= ts;
        do @(posedge clk); while (in_stall);
        items_sent++;
    endtask

    task automatic offer(input logic [1:0] f, input logic [POS_BITS-1:0] cnt,
                         input logic [STAMP_BITS-1:0] ts);
        int gap;
        if (burst_left == 0)
        begin
            case ($urandom_range(0, 4))
                0: gap = 0;
                1, 2: gap = $urandom_range(1, 3);
                3: gap = $urandom_range(4, 12);
                default: gap = $urandom_range(20, 40);
            endcase
            if ($urandom_range(0, 3) == 0)
                burst_left = $urandom_range(30, 80);
            else
                burst_left = $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        send_item(f, cnt, ts);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic set_config(input int res, input int win);
        cfg_we <= 1'b1;
        cfg_index <= REG_RESOLUTION;
        cfg_data <= CFG_DATA_BITS'(res);
        @(posedge clk);
        cfg_index <= REG_WINDOW;
        cfg_data <= CFG_DATA_BITS'(win);
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_run++;
    endtask

    // down-counting time moves on; a wrap of the counter is reported first
    task automatic tick_stamp(input int pos);
        int d;
        case ($urandom_range(0, 3))
            0: d = $urandom_range(1, 50);
            1: d = $urandom_range(50, 5000);
            2: d = $urandom_range(5000, 500000);
            default: d = $urandom_range(500000, STAMP_SPAN - 1);
        endcase
        if (d > stamp)
        begin
            offer(FUNC_WRAP, POS_BITS'(pos), STAMP_BITS'(stamp));
            stamp = stamp + STAMP_SPAN - d;
        end
        else
        begin
            stamp = stamp - d;
        end
    endtask

    task automatic run_phase(input int res, input int win, input int n_items);
        int pos;
        int dir;
        int k;
        int r;
        drain();
        set_config(res, win);
        pos = $urandom_range(0, res - 1);
        dir = 1;
        offer(FUNC_REARM, POS_BITS'(pos), STAMP_BITS'(stamp));
        for (k = 0; k < n_items; k++)
        begin
            if (k == n_items / 2)
                drain();
            r = $urandom_range(0, 99);
            if (r < 72)
            begin
                if ($urandom_range(0, 11) == 0)
                    dir = -dir;
                pos += ($urandom_range(0, 15) == 0) ? 2 * dir : dir;
                if (pos >= res)
                    pos -= res;
                if (pos < 0)
                    pos += res;
                tick_stamp(pos);
                offer(FUNC_SAMPLE, POS_BITS'(pos), STAMP_BITS'(stamp));
            end
            else if (r < 80)
            begin
                repeat ($urandom_range(1, 3))
                    offer(FUNC_WRAP, POS_BITS'(pos), STAMP_BITS'($urandom));
            end
            else if (r < 86)
            begin
                if ($urandom_range(0, 1) == 0)
                    pos = $urandom_range(0, res - 1);
                offer(FUNC_REARM, POS_BITS'(pos), STAMP_BITS'(stamp));
            end
            else if (r < 93)
            begin
                offer(FUNC_SAMPLE, POS_BITS'($urandom), STAMP_BITS'($urandom));
            end
            else if (r < 96)
            begin
                offer(FUNC_UNUSED, POS_BITS'($urandom), STAMP_BITS'($urandom));
            end
            else
            begin
                offer(FUNC_SAMPLE, POS_BITS'(pos), STAMP_BITS'($urandom));
            end
        end
    endtask

    initial
    begin : receiver
        int seg;
        int len;
        int mode;
        seg = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            seg++;
            if (seg % 12 == 3)
            begin
                // long hold so the block fills up and stalls its input
                repeat (200)
                begin
                    @(posedge clk);
                    out_stall <= 1'b1;
                end
            end
            else
            begin
                mode = $urandom_range(0, 3);
                len = $urandom_range(8, 60);
                repeat (len)
                begin
                    @(posedge clk);
                    case (mode)
                        0: out_stall <= 1'b0;
                        1: out_stall <= ($urandom_range(0, 3) == 0);
                        2: out_stall <= ($urandom_range(0, 3) != 0);
                        default: out_stall <= ~out_stall;
                    endcase
                end
            end
        end
    end

    initial
    begin : stimulus
        int waited;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset marks at 10 and 4086, last stamp zero
        offer(FUNC_SAMPLE, 16'd5, 24'd100);
        offer(FUNC_SAMPLE, 16'd10, 24'hFFFFFF);
        offer(FUNC_SAMPLE, 16'd20, 24'hFFFFFE);
        offer(FUNC_SAMPLE, 16'd10, 24'h000000);
        offer(FUNC_SAMPLE, 16'd0, 24'h000000);
        offer(FUNC_SAMPLE, 16'd4086, 24'h000123);
        offer(FUNC_SAMPLE, 16'd0, 24'hF00000);
        offer(FUNC_WRAP, 16'd0, 24'hAAAAAA);
        offer(FUNC_WRAP, 16'd0, 24'h555555);
        offer(FUNC_WRAP, 16'd0, 24'h000000);
        offer(FUNC_SAMPLE, 16'd10, 24'hEFF000);
        offer(FUNC_REARM, 16'hFFFF, 24'h000000);
        offer(FUNC_SAMPLE, 16'd65525, 24'h800000);
        offer(FUNC_UNUSED, 16'hFFFF, 24'hFFFFFF);

        // new settings apply at the next re-arm or crossing; here both marks coincide
        drain();
        set_config(20, 10);
        offer(FUNC_SAMPLE, 16'd61439, 24'h7FFF00);
        offer(FUNC_SAMPLE, 16'd61429, 24'h7FF000);
        offer(FUNC_REARM, 16'd5, 24'h7F0000);
        offer(FUNC_SAMPLE, 16'd15, 24'h7E0000);

        drain();
        set_config(22, 1);
        offer(FUNC_REARM, 16'd0, 24'h700000);
        offer(FUNC_SAMPLE, 16'd21, 24'h6FFFF0);
        offer(FUNC_SAMPLE, 16'd0, 24'h6FFF00);

        drain();
        set_config(65536, 10);
        offer(FUNC_REARM, 16'd65530, 24'h680000);
        offer(FUNC_SAMPLE, 16'd4, 24'h670000);
        offer(FUNC_SAMPLE, 16'd65530, 24'h660000);

        run_phase(4096, 10, 150);
        run_phase(22, 1, 115);
        run_phase(65536, 1, 115);
        run_phase(22, 10, 115);
        run_phase(65536, 10, 115);
        run_phase($urandom_range(22, 65536), $urandom_range(1, 10), 130);

        in_valid <= 1'b0;
        waited = 0;
        do
        begin
            @(posedge clk);
            waited++;
        end
        while (outstanding != 0 && waited < 20000);
        repeat (60) @(posedge clk);

        $display("run covered %0d items over %0d register settings", items_sent, settings_run);
        $display("%0d mark crossings and %0d stop detections were predicted", crossings, stops);
        if (checker_errors == 0 && outstanding == 0)
            $display("encoder_window_period_speed test passed");
        else
            $display("encoder_window_period_speed test failed");
        $finish;
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("encoder_window_period_speed test failed");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/ewps_pkg.sv
rtl/ewps_front.sv
rtl/ewps_queue.sv
rtl/ewps_back.sv
rtl/encoder_window_period_speed.sv
sim/ewps_checker.sv
sim/tb_encoder_window_period_speed.sv
